@@ hdl/clf_pkg.sv @@
// Shared types, codes and helpers for the clock linear fit block.
package clf_pkg;

  localparam int unsigned PointsW = 7;
  localparam int unsigned SumW    = 36;

  localparam logic [1:0] FitOk       = 2'd0;
  localparam logic [1:0] FitFew      = 2'd1;
  localparam logic [1:0] FitZeroDen  = 2'd2;
  localparam logic [1:0] FitOverflow = 2'd3;

  // Handshake status of a shared arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a 128-bit two's complement value to the signed 64-bit range.
  function automatic logic [63:0] sat64(input logic [127:0] a);
    logic [63:0] r;
    if ((a[127:63] == '0) || (a[127:63] == '1)) begin
      r = a[63:0];
    end else if (a[127]) begin
      r = {1'b1, 63'd0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ hdl/clf_mul.sv @@
// Shared 64x64 multiplier built from four 32x32 partial products.
module clf_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output logic [127:0]        prod_o,
  output clf_pkg::unit_stat_t stat_o
);
  import clf_pkg::*;

  logic [63:0]  a_q, b_q, pp_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic [1:0]   psh_q;
  logic         run_q, pvld_q, done_q;
  logic [31:0]  ah, bh;

  assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pvld_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        run_q  <= 1'b1;
        pvld_q <= 1'b0;
      end else if (run_q) begin
        // accumulate the previous partial product, form the next one
        if (pvld_q) begin
          acc_q <= acc_q + ({64'd0, pp_q} << {psh_q, 5'd0});
        end
        if (cnt_q == 3'd4) begin
          run_q  <= 1'b0;
          pvld_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          pp_q   <= {32'd0, ah} * {32'd0, bh};
          psh_q  <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
          pvld_q <= 1'b1;
          cnt_q  <= cnt_q + 3'd1;
        end
      end
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

endmodule

@@ hdl/clf_div.sv @@
// Restoring signed divider, one quotient bit per cycle, round half away from zero.
module clf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [127:0]        num_i,
  input  logic [127:0]        den_i,
  output logic [127:0]        quot_o,
  output clf_pkg::unit_stat_t stat_o
);
  import clf_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_ITER, D_ROUND, D_SIGN} dstate_e;

  dstate_e      st_q;
  logic [127:0] nm_q, d_q, r_q, q_q, r2, rs;
  logic [6:0]   cnt_q;
  logic         neg_q, done_q, ge;

  assign r2 = {r_q[126:0], nm_q[127]};
  assign ge = (r2 >= d_q);
  assign rs = {r_q[126:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        D_IDLE: begin
          if (go_i) begin
            neg_q <= num_i[127];
            nm_q  <= num_i[127] ? (~num_i + 128'd1) : num_i;
            d_q   <= den_i;
            r_q   <= '0;
            q_q   <= '0;
            cnt_q <= '0;
            st_q  <= D_ITER;
          end
        end
        D_ITER: begin
          r_q   <= ge ? (r2 - d_q) : r2;
          q_q   <= {q_q[126:0], ge};
          nm_q  <= {nm_q[126:0], 1'b0};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) begin
            st_q <= D_ROUND;
          end
        end
        D_ROUND: begin
          if (rs >= d_q) begin
            q_q <= q_q + 128'd1;
          end
          st_q <= D_SIGN;
        end
        D_SIGN: begin
          if (neg_q) begin
            q_q <= ~q_q + 128'd1;
          end
          done_q <= 1'b1;
          st_q   <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

  assign quot_o      = q_q;
  assign stat_o.busy = (st_q != D_IDLE);
  assign stat_o.done = done_q;

endmodule

@@ hdl/clock_linear_fit.sv @@
// Clock linear fit: least-squares fit of real time against a free-running counter.
// A first or rejected sample that is not the last is taken without raising busy; an accumulated
// sample holds busy for three passes through the shared 4-partial multiplier. A last sample
// that fails on overflow or too few points strobes its result through S_FIT and the result
// register; past accumulation a zero denominator is reported from S_DEN2, and the time of a
// full fit is set mostly by two divisions. A new sample is taken only while idle; the result
// strobe cannot be stalled. Reset clears all sums, the reference sample and the point count.
module clock_linear_fit #(
  parameter int unsigned MAX_POINTS      = 64,
  parameter int unsigned DELTA_BITS      = 29,
  parameter int unsigned SLOPE_FRAC_BITS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        real_time_us_i,
  input  logic [63:0]        counter_value_i,
  input  logic               last_sample_i,
  output logic               done_o,
  output logic signed [63:0] slope_fixed_o,
  output logic signed [63:0] offset_us_o,
  output logic [1:0]         fit_status_o
);
  import clf_pkg::*;

  // Sequencer states: accumulate one sample, then the fit steps.
  typedef enum logic [3:0] {
    S_IDLE, S_ACC_TT, S_ACC_TC, S_ACC_CC, S_FIT, S_DEN1, S_DEN2,
    S_NUM1, S_NUM2, S_DIVS, S_QM, S_PM, S_PL, S_DIVO, S_OFF
  } state_e;

  localparam logic [63:0] FracMask = (64'd1 << SLOPE_FRAC_BITS) - 64'd1;

  state_e               state_q;
  logic [63:0]          ref_rt_q, ref_ct_q;
  logic [SumW-1:0]      s1_q, s2_q;
  logic [63:0]          s11_q, s12_q, s22_q;
  logic [PointsW-1:0]   pts_q;
  logic                 ovf_q, last_q, neg_q;
  logic [DELTA_BITS-1:0] dt_q, dc_q;
  logic [127:0]         tmp_q, den_q, ph_q, off_q;
  logic [63:0]          slope_q, mag_q;

  // Shared unit requests.
  logic                 mul_go_q, div_go_q;
  logic [63:0]          mul_a_q, mul_b_q;
  logic [127:0]         div_num_q, div_den_q;
  logic [127:0]         mul_prod, div_quot;
  unit_stat_t           mul_stat, div_stat;

  // Result registers.
  logic                 done_q;
  logic [63:0]          slope_out_q, off_out_q;
  logic [1:0]           stat_out_q;

  // Sample deltas against the reference.
  logic [63:0]          dt_full, dc_full;
  logic                 delta_big;
  logic [127:0]         den_w, s1_shift, off_w;
  logic [63:0]          slope_w, mag_w;

  // Result emission, decided per state.
  logic                 emit;
  logic [1:0]           emit_status;
  logic [63:0]          emit_slope, emit_off;

  clf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .prod_o (mul_prod),
    .stat_o (mul_stat)
  );

  clf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .quot_o (div_quot),
    .stat_o (div_stat)
  );

  assign dt_full   = real_time_us_i - ref_rt_q;
  assign dc_full   = counter_value_i - ref_ct_q;
  assign delta_big = (dt_full[63:DELTA_BITS] != '0) || (dc_full[63:DELTA_BITS] != '0);

  assign den_w    = tmp_q - mul_prod;
  assign s1_shift = {92'd0, s1_q} << SLOPE_FRAC_BITS;
  assign off_w    = neg_q ? (off_q + ph_q) : (off_q - ph_q);
  assign slope_w  = sat64(div_quot);
  assign mag_w    = slope_w[63] ? (~slope_w + 64'd1) : slope_w;

  always_comb begin
    emit        = 1'b0;
    emit_status = FitOk;
    emit_slope  = '0;
    emit_off    = '0;
    case (state_q)
      S_FIT: begin
        // overflow wins over too few points
        if (ovf_q) begin
          emit        = 1'b1;
          emit_status = FitOverflow;
        end else if (pts_q < PointsW'(2)) begin
          emit        = 1'b1;
          emit_status = FitFew;
        end
      end
      S_DEN2: begin
        if (mul_stat.done && (den_w == '0)) begin
          emit        = 1'b1;
          emit_status = FitZeroDen;
        end
      end
      S_OFF: begin
        emit       = 1'b1;
        emit_slope = slope_q;
        emit_off   = sat64(off_w);
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ref_rt_q <= '0;
      ref_ct_q <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
      s11_q    <= '0;
      s12_q    <= '0;
      s22_q    <= '0;
      pts_q    <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
      if (emit) begin
        // deliver the result and drop the whole set
        done_q      <= 1'b1;
        stat_out_q  <= emit_status;
        slope_out_q <= emit_slope;
        off_out_q   <= emit_off;
        ref_rt_q    <= '0;
        ref_ct_q    <= '0;
        s1_q        <= '0;
        s2_q        <= '0;
        s11_q       <= '0;
        s12_q       <= '0;
        s22_q       <= '0;
        pts_q       <= '0;
        ovf_q       <= 1'b0;
        state_q     <= S_IDLE;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (start) begin
              last_q <= last_sample_i;
              if (pts_q >= PointsW'(MAX_POINTS)) begin
                ovf_q   <= 1'b1;
                state_q <= last_sample_i ? S_FIT : S_IDLE;
              end else if (pts_q == '0) begin
                // first sample of a set becomes the reference
                ref_rt_q <= real_time_us_i;
                ref_ct_q <= counter_value_i;
                pts_q    <= PointsW'(1);
                state_q  <= last_sample_i ? S_FIT : S_IDLE;
              end else if (delta_big) begin
                ovf_q   <= 1'b1;
                state_q <= last_sample_i ? S_FIT : S_IDLE;
              end else begin
                dt_q     <= dt_full[DELTA_BITS-1:0];
                dc_q     <= dc_full[DELTA_BITS-1:0];
                s1_q     <= s1_q + SumW'(dt_full[DELTA_BITS-1:0]);
                s2_q     <= s2_q + SumW'(dc_full[DELTA_BITS-1:0]);
                mul_go_q <= 1'b1;
                mul_a_q  <= 64'(dt_full[DELTA_BITS-1:0]);
                mul_b_q  <= 64'(dt_full[DELTA_BITS-1:0]);
                state_q  <= S_ACC_TT;
              end
            end
          end
          S_ACC_TT: begin
            if (mul_stat.done) begin
              s11_q    <= s11_q + mul_prod[63:0];
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(dt_q);
              mul_b_q  <= 64'(dc_q);
              state_q  <= S_ACC_TC;
            end
          end
          S_ACC_TC: begin
            if (mul_stat.done) begin
              s12_q    <= s12_q + mul_prod[63:0];
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(dc_q);
              mul_b_q  <= 64'(dc_q);
              state_q  <= S_ACC_CC;
            end
          end
          S_ACC_CC: begin
            if (mul_stat.done) begin
              s22_q   <= s22_q + mul_prod[63:0];
              pts_q   <= pts_q + PointsW'(1);
              state_q <= last_q ? S_FIT : S_IDLE;
            end
          end
          S_FIT: begin
            // n * S22
            mul_go_q <= 1'b1;
            mul_a_q  <= 64'(pts_q);
            mul_b_q  <= s22_q;
            state_q  <= S_DEN1;
          end
          S_DEN1: begin
            if (mul_stat.done) begin
              tmp_q    <= mul_prod;
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(s2_q);
              mul_b_q  <= 64'(s2_q);
              state_q  <= S_DEN2;
            end
          end
          S_DEN2: begin
            if (mul_stat.done) begin
              den_q    <= den_w;
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(pts_q);
              mul_b_q  <= s12_q;
              state_q  <= S_NUM1;
            end
          end
          S_NUM1: begin
            if (mul_stat.done) begin
              tmp_q    <= mul_prod;
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(s1_q);
              mul_b_q  <= 64'(s2_q);
              state_q  <= S_NUM2;
            end
          end
          S_NUM2: begin
            if (mul_stat.done) begin
              div_go_q  <= 1'b1;
              div_num_q <= den_w << SLOPE_FRAC_BITS;
              div_den_q <= den_q;
              state_q   <= S_DIVS;
            end
          end
          S_DIVS: begin
            if (div_stat.done) begin
              slope_q  <= slope_w;
              neg_q    <= slope_w[63];
              mag_q    <= mag_w;
              mul_go_q <= 1'b1;
              mul_a_q  <= mag_w;
              mul_b_q  <= 64'(s2_q);
              state_q  <= S_QM;
            end
          end
          S_QM: begin
            if (mul_stat.done) begin
              // S1 scaled minus slope times S2
              tmp_q    <= neg_q ? (s1_shift + mul_prod) : (s1_shift - mul_prod);
              mul_go_q <= 1'b1;
              mul_a_q  <= mag_q;
              mul_b_q  <= ref_ct_q;
              state_q  <= S_PM;
            end
          end
          S_PM: begin
            if (mul_stat.done) begin
              // split slope times reference count into integer and fraction
              ph_q     <= mul_prod >> SLOPE_FRAC_BITS;
              mul_go_q <= 1'b1;
              mul_a_q  <= 64'(pts_q);
              mul_b_q  <= mul_prod[63:0] & FracMask;
              state_q  <= S_PL;
            end
          end
          S_PL: begin
            if (mul_stat.done) begin
              div_go_q  <= 1'b1;
              div_num_q <= neg_q ? (tmp_q + mul_prod) : (tmp_q - mul_prod);
              div_den_q <= {121'd0, pts_q} << SLOPE_FRAC_BITS;
              state_q   <= S_DIVO;
            end
          end
          S_DIVO: begin
            if (div_stat.done) begin
              off_q   <= div_quot + {64'd0, ref_rt_q};
              state_q <= S_OFF;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slope_fixed_o = slope_out_q;
  assign offset_us_o   = off_out_q;
  assign fit_status_o  = stat_out_q;

  // A result only ends a busy period.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a fit in progress");

  // A failed fit reports zero slope and offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (fit_status_o != FitOk)) |-> ((slope_fixed_o == '0) && (offset_us_o == '0)))
    else $error("failed fit carries nonzero fields");

  // The shared multiplier is never restarted while it works.
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_go_q |-> !mul_stat.busy)
    else $error("multiplier request while busy");

  // A delivered result leaves an empty set.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((pts_q == '0) && !ovf_q))
    else $error("state not cleared after result");

endmodule
